>>> sv/assert_macros.svh
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/tfsq_pkg.sv
package tfsq_pkg;

   localparam int FACT_DEPTH     = 64;
   localparam int VARIABLE_SLOTS = 8;
   localparam int HIT_LIMIT      = 16;
   localparam int IDX_W          = $clog2(FACT_DEPTH);

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_BAD   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOCHANGE = 3'd1,
      ST_FULL     = 3'd2,
      ST_BADARG   = 3'd3,
      ST_CONTRA   = 3'd4,
      ST_NOEVID   = 3'd5,
      ST_AMBIG    = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      AK_NONE    = 3'd0,
      AK_ABSENT  = 3'd1,
      AK_DIRECT  = 3'd2,
      AK_AMBIG   = 3'd3,
      AK_CONTRA  = 3'd4
   } answer_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_DONE = 2'd2
   } state_type;

   typedef struct packed {
      logic [15:0] s;
      logic [15:0] p;
      logic [15:0] o;
      logic        neg;
   } fact_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] subject_value;
      logic        subject_is_variable;
      logic [15:0] predicate_value;
      logic        predicate_is_variable;
      logic [15:0] object_value;
      logic        object_is_variable;
      logic        negated;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  answer_kind;
      logic [15:0] found_subject;
      logic [15:0] found_predicate;
      logic [15:0] found_object;
      logic        found_negated;
      logic [7:0]  found_index;
      logic [7:0]  match_count;
      logic [7:0]  stored_facts;
      logic [15:0] contradiction_total;
   } rsp_type;

   // What one cell reports about its fact against the current pattern
   typedef struct packed {
      logic live;
      logic exact;
      logic opposite;
      logic hit;
      logic opp_hit;
   } cell_flags_type;

   // Match a pattern (with per-fact variable binding) against a fact
   function automatic logic pattern_fits(req_type q, logic neg, fact_type f);
      logic ok;
      ok = (f.neg == neg);
      if (!q.subject_is_variable && q.subject_value != f.s) ok = 1'b0;
      if (!q.predicate_is_variable && q.predicate_value != f.p) ok = 1'b0;
      if (!q.object_is_variable && q.object_value != f.o) ok = 1'b0;
      if (q.subject_is_variable && q.predicate_is_variable &&
          q.subject_value == q.predicate_value && f.s != f.p) ok = 1'b0;
      if (q.subject_is_variable && q.object_is_variable &&
          q.subject_value == q.object_value && f.s != f.o) ok = 1'b0;
      if (q.predicate_is_variable && q.object_is_variable &&
          q.predicate_value == q.object_value && f.p != f.o) ok = 1'b0;
      return ok;
   endfunction

endpackage

>>> sv/tfsq_if.sv
interface tfsq_req_if (input logic clock);
   logic             valid;
   logic             ready;
   tfsq_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tfsq_rsp_if (input logic clock);
   logic             valid;
   logic             ready;
   tfsq_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/triple_fact_store_query_top.sv
// Channel | Dir | Payload
// req     | in  | tfsq_pkg::req_type (command, pattern or fact)
// rsp     | out | tfsq_pkg::rsp_type (status, answer, first match, counts)
//
// Facts sit in a ring of FACT_DEPTH cells that rotates one place per cycle
// while an add or query scans. Add and query scan one full rotation (index 0
// at the read point first), then report through the output register. Clear and
// bad commands pass through the scan state without rotating the ring.
// An add writes its fact into the cell at the fill count as it reports.
// Reset empties the ring and counters at once; no clearing pass.
// A finished word holds in the output register until taken; the next word
// is accepted from the cycle after the result has left.
`include "assert_macros.svh"
module triple_fact_store_query_top (
   input logic clock,
   input logic reset,
   tfsq_req_if.sink   req,
   tfsq_rsp_if.source rsp
);
   localparam int D = tfsq_pkg::FACT_DEPTH;
   localparam int W = tfsq_pkg::IDX_W + 1;

   tfsq_pkg::state_type state_ff, state_in;
   tfsq_pkg::req_type   cmd_ff, cmd_in;
   logic [W-1:0]        step_ff, step_in;
   logic [7:0]          total_ff, total_in;
   logic [15:0]         contra_ff, contra_in;
   logic [7:0]          hits_ff, hits_in, opp_ff, opp_in;
   logic                first_ok_ff, first_ok_in, dup_ff, dup_in;
   logic [15:0]         nopp_ff, nopp_in;
   logic [7:0]          first_idx_ff, first_idx_in;
   tfsq_pkg::fact_type  first_ff, first_in;
   tfsq_pkg::rsp_type   out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   logic                shift, clear_all, add_now, bad_slot;
   tfsq_pkg::fact_type  new_fact;
   logic                live_w [D];
   tfsq_pkg::fact_type  fact_w [D];
   tfsq_pkg::cell_flags_type flags_w [D];
   tfsq_pkg::cell_flags_type head;
   logic [8:0]          sum;
   logic [16:0]         csum;

   // ring of cells: cell 0 is the read point, fed from cell 1; the last cell is fed from cell 0
   for (genvar g = 0; g < D; g++) begin : g_ring
      tfsq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .clear     (clear_all),
         .append    (add_now && (total_ff == 8'(g))),
         .new_fact  (new_fact),
         .prev_live (live_w[(g + 1) % D]),
         .prev_fact (fact_w[(g + 1) % D]),
         .pattern   (cmd_ff),
         .live      (live_w[g]),
         .fact      (fact_w[g]),
         .flags     (flags_w[g])
      );
   end

   assign head = flags_w[0];
   assign new_fact = '{s: cmd_ff.subject_value, p: cmd_ff.predicate_value,
                       o: cmd_ff.object_value, neg: cmd_ff.negated};
   assign bad_slot =
      (cmd_ff.subject_is_variable &&
       cmd_ff.subject_value >= 16'(tfsq_pkg::VARIABLE_SLOTS)) ||
      (cmd_ff.predicate_is_variable &&
       cmd_ff.predicate_value >= 16'(tfsq_pkg::VARIABLE_SLOTS)) ||
      (cmd_ff.object_is_variable &&
       cmd_ff.object_value >= 16'(tfsq_pkg::VARIABLE_SLOTS));
   assign sum  = {1'b0, hits_ff} + {1'b0, opp_ff};
   assign csum = {1'b0, contra_ff} + 17'(nopp_ff);

   // write the new fact into the cell whose index equals the fill count
   assign add_now = (state_ff == tfsq_pkg::S_DONE) && (cmd_ff.command == tfsq_pkg::CMD_ADD)
                    && !dup_ff && (total_ff < 8'(D));

   assign req.ready   = (state_ff == tfsq_pkg::S_IDLE) && !out_valid_ff;
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tfsq_pkg::S_IDLE;
         total_ff     <= '0;
         contra_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         contra_ff    <= contra_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff       <= cmd_in;
      step_ff      <= step_in;
      hits_ff      <= hits_in;
      opp_ff       <= opp_in;
      first_ok_ff  <= first_ok_in;
      dup_ff       <= dup_in;
      nopp_ff      <= nopp_in;
      first_idx_ff <= first_idx_in;
      first_ff     <= first_in;
      out_ff       <= out_in;
   end

   // sequencer: rotate the ring once per add or query, gather, then report
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      step_in      = step_ff;
      total_in     = total_ff;
      contra_in    = contra_ff;
      hits_in      = hits_ff;
      opp_in       = opp_ff;
      first_ok_in  = first_ok_ff;
      dup_in       = dup_ff;
      nopp_in      = nopp_ff;
      first_idx_in = first_idx_ff;
      first_in     = first_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      shift        = 1'b0;
      clear_all    = 1'b0;
      if (rsp.valid && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         tfsq_pkg::S_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in      = req.payload;
               step_in     = '0;
               hits_in     = '0;
               opp_in      = '0;
               first_ok_in = 1'b0;
               dup_in      = 1'b0;
               nopp_in     = '0;
               first_idx_in = '0;
               first_in    = '0;
               state_in    = tfsq_pkg::S_SCAN;
            end
         end
         tfsq_pkg::S_SCAN: begin
            if (cmd_ff.command == tfsq_pkg::CMD_ADD ||
                cmd_ff.command == tfsq_pkg::CMD_QUERY) begin
               shift = 1'b1;
               if (head.exact) dup_in = 1'b1;
               if (head.opposite && nopp_ff != 16'hFFFF) nopp_in = nopp_ff + 16'd1;
               if (head.hit) begin
                  if (!first_ok_ff) begin
                     first_ok_in  = 1'b1;
                     first_idx_in = 8'(step_ff);
                     first_in     = fact_w[0];
                  end
                  if (hits_ff < 8'(tfsq_pkg::HIT_LIMIT)) hits_in = hits_ff + 8'd1;
               end
               if (head.opp_hit && opp_ff < 8'(tfsq_pkg::HIT_LIMIT)) opp_in = opp_ff + 8'd1;
               step_in = step_ff + W'(1);
               if (step_ff == W'(D - 1)) state_in = tfsq_pkg::S_DONE;
            end else begin
               state_in = tfsq_pkg::S_DONE;
            end
         end
         tfsq_pkg::S_DONE: begin
            out_in = '0;
            unique case (cmd_ff.command)
               tfsq_pkg::CMD_ADD: begin
                  if (dup_ff) begin
                     out_in.status = tfsq_pkg::ST_NOCHANGE;
                  end else if (total_ff >= 8'(D)) begin
                     out_in.status = tfsq_pkg::ST_FULL;
                  end else begin
                     out_in.status = tfsq_pkg::ST_OK;
                     total_in = total_ff + 8'd1;
                     contra_in = csum[16] ? 16'hFFFF : csum[15:0];
                  end
               end
               tfsq_pkg::CMD_QUERY: begin
                  if (bad_slot) begin
                     out_in.status = tfsq_pkg::ST_BADARG;
                  end else if (hits_ff != 8'd0 && opp_ff != 8'd0) begin
                     out_in.status      = tfsq_pkg::ST_CONTRA;
                     out_in.answer_kind = tfsq_pkg::AK_CONTRA;
                     out_in.match_count = sum[8] ? 8'hFF : sum[7:0];
                  end else if (hits_ff == 8'd0) begin
                     out_in.status      = tfsq_pkg::ST_NOEVID;
                     out_in.answer_kind = tfsq_pkg::AK_ABSENT;
                  end else if (hits_ff > 8'd1) begin
                     out_in.status      = tfsq_pkg::ST_AMBIG;
                     out_in.answer_kind = tfsq_pkg::AK_AMBIG;
                     out_in.match_count = hits_ff;
                  end else begin
                     out_in.status      = tfsq_pkg::ST_OK;
                     out_in.answer_kind = tfsq_pkg::AK_DIRECT;
                     out_in.match_count = 8'd1;
                  end
                  if (!bad_slot && hits_ff != 8'd0) begin
                     out_in.found_subject   = first_ff.s;
                     out_in.found_predicate = first_ff.p;
                     out_in.found_object    = first_ff.o;
                     out_in.found_negated   = first_ff.neg;
                     out_in.found_index     = first_idx_ff;
                  end
               end
               tfsq_pkg::CMD_CLEAR: begin
                  out_in.status = tfsq_pkg::ST_OK;
                  clear_all = 1'b1;
                  total_in  = '0;
                  contra_in = '0;
               end
               default: begin
                  out_in.status = tfsq_pkg::ST_BADARG;
               end
            endcase
            out_in.stored_facts        = total_in;
            out_in.contradiction_total = contra_in;
            out_valid_in = 1'b1;
            state_in     = tfsq_pkg::S_IDLE;
         end
         default: state_in = tfsq_pkg::S_IDLE;
      endcase
   end

   `ASSERT_ALWAYS(a_count_range, clock, reset, total_ff <= 8'(D), "fill count beyond depth")
   `ASSERT_NEXT(a_busy_blocks, clock, reset, state_ff == tfsq_pkg::S_SCAN, !req.ready,
                "word accepted mid scan")
   `ASSERT_NEXT(a_done_reports, clock, reset, state_ff == tfsq_pkg::S_DONE, rsp.valid,
                "no result after scan")
endmodule

>>> sv/tfsq_cell.sv
// One slot of the fact chain: holds a fact, compares it with the pattern
module tfsq_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  logic               clear,
   input  logic               append,
   input  tfsq_pkg::fact_type new_fact,
   input  logic               prev_live,
   input  tfsq_pkg::fact_type prev_fact,
   input  tfsq_pkg::req_type  pattern,
   output logic               live,
   output tfsq_pkg::fact_type fact,
   output tfsq_pkg::cell_flags_type flags
);
   logic               live_ff, live_in;
   tfsq_pkg::fact_type fact_ff, fact_in;
   tfsq_pkg::fact_type probe;

   // drop on clear, take the new fact on append, else advance on shift
   always_comb begin
      live_in = live_ff;
      fact_in = fact_ff;
      if (clear) begin
         live_in = 1'b0;
      end else if (append) begin
         live_in = 1'b1;
         fact_in = new_fact;
      end else if (shift) begin
         live_in = prev_live;
         fact_in = prev_fact;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
      fact_ff <= fact_in;
   end

   // compare the fact at this cell
   always_comb begin
      probe.s   = pattern.subject_value;
      probe.p   = pattern.predicate_value;
      probe.o   = pattern.object_value;
      probe.neg = pattern.negated;
      flags.live     = live_ff;
      flags.exact    = live_ff && (fact_ff == probe);
      flags.opposite = live_ff && (fact_ff.s == probe.s) && (fact_ff.p == probe.p)
                       && (fact_ff.o == probe.o) && (fact_ff.neg != probe.neg);
      flags.hit      = live_ff && tfsq_pkg::pattern_fits(pattern, pattern.negated, fact_ff);
      flags.opp_hit  = live_ff && tfsq_pkg::pattern_fits(pattern, ~pattern.negated, fact_ff);
   end

   assign live = live_ff;
   assign fact = fact_ff;
endmodule

>>> test/tfsq_tb_if.sv
`timescale 1ns / 100ps
// Predictor types for the testbench
package tfsq_tb_pkg;

   // One stored fact as the predictor keeps it
   typedef struct packed {
      logic [15:0] s;
      logic [15:0] p;
      logic [15:0] o;
      logic        neg;
   } tb_fact_type;
endpackage

>>> test/triple_fact_store_query_top_tb.sv
`timescale 1ns / 100ps
module triple_fact_store_query_top_tb;

   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int HOLD_OFF_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tfsq_req_if req (clock);
   tfsq_rsp_if rsp (clock);

   triple_fact_store_query_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #1 clock = ~clock;

   // Predictor state
   tfsq_tb_pkg::tb_fact_type store_facts[tfsq_pkg::FACT_DEPTH];
   int                       store_count;
   int                       store_contra;
   tfsq_pkg::rsp_type        pending_answers[$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_off_trigger = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int fail_count = 0;
   int words_sent;
   int words_checked = 0;
   int idle_cycles = 0;

   // Term check with per-fact variable binding
   function automatic logic term_ok(logic [15:0] v, logic is_var, logic [15:0] seen,
                                    ref logic bound[tfsq_pkg::VARIABLE_SLOTS],
                                    ref logic [15:0] bval[tfsq_pkg::VARIABLE_SLOTS]);
      if (!is_var) return v == seen;
      if (v >= 16'(tfsq_pkg::VARIABLE_SLOTS)) return 1'b0;
      if (!bound[v[2:0]]) begin
         bound[v[2:0]] = 1'b1;
         bval[v[2:0]] = seen;
         return 1'b1;
      end
      return bval[v[2:0]] == seen;
   endfunction

   function automatic logic fact_matches(tfsq_pkg::req_type q, logic neg,
                                         tfsq_tb_pkg::tb_fact_type f);
      logic        bound[tfsq_pkg::VARIABLE_SLOTS];
      logic [15:0] bval[tfsq_pkg::VARIABLE_SLOTS];
      foreach (bound[k]) begin
         bound[k] = 1'b0;
         bval[k] = '0;
      end
      if (f.neg != neg) return 1'b0;
      if (!term_ok(q.subject_value, q.subject_is_variable, f.s, bound, bval)) return 1'b0;
      if (!term_ok(q.predicate_value, q.predicate_is_variable, f.p, bound, bval))
         return 1'b0;
      return term_ok(q.object_value, q.object_is_variable, f.o, bound, bval);
   endfunction

   // Work out the answer to one command and advance the store
   function automatic tfsq_pkg::rsp_type predict_answer(tfsq_pkg::req_type q);
      tfsq_pkg::rsp_type        r;
      tfsq_tb_pkg::tb_fact_type f;
      int                       hits, opp, first;
      logic                     dup;
      r = '0;
      f.s = q.subject_value;
      f.p = q.predicate_value;
      f.o = q.object_value;
      f.neg = q.negated;
      unique case (q.command)
         tfsq_pkg::CMD_ADD: begin
            dup = 1'b0;
            for (int i = 0; i < store_count; i++)
               if (store_facts[i] == f) dup = 1'b1;
            if (dup) r.status = tfsq_pkg::ST_NOCHANGE;
            else if (store_count >= tfsq_pkg::FACT_DEPTH) r.status = tfsq_pkg::ST_FULL;
            else begin
               for (int i = 0; i < store_count; i++)
                  if (store_facts[i].s == f.s && store_facts[i].p == f.p &&
                      store_facts[i].o == f.o && store_facts[i].neg != f.neg &&
                      store_contra < 65535)
                     store_contra++;
               store_facts[store_count] = f;
               store_count++;
               r.status = tfsq_pkg::ST_OK;
            end
         end
         tfsq_pkg::CMD_QUERY: begin
            if ((q.subject_is_variable &&
                 q.subject_value >= 16'(tfsq_pkg::VARIABLE_SLOTS)) ||
                (q.predicate_is_variable &&
                 q.predicate_value >= 16'(tfsq_pkg::VARIABLE_SLOTS)) ||
                (q.object_is_variable &&
                 q.object_value >= 16'(tfsq_pkg::VARIABLE_SLOTS))) begin
               r.status = tfsq_pkg::ST_BADARG;
            end else begin
               hits = 0;
               opp = 0;
               first = -1;
               for (int i = 0; i < store_count; i++) begin
                  if (fact_matches(q, q.negated, store_facts[i])) begin
                     if (first < 0) first = i;
                     if (hits < tfsq_pkg::HIT_LIMIT) hits++;
                  end
                  if (fact_matches(q, ~q.negated, store_facts[i]) &&
                      opp < tfsq_pkg::HIT_LIMIT)
                     opp++;
               end
               if (hits == 0) begin
                  r.status = tfsq_pkg::ST_NOEVID;
                  r.answer_kind = tfsq_pkg::AK_ABSENT;
               end else begin
                  r.found_subject = store_facts[first].s;
                  r.found_predicate = store_facts[first].p;
                  r.found_object = store_facts[first].o;
                  r.found_negated = store_facts[first].neg;
                  r.found_index = 8'(first);
                  if (opp > 0) begin
                     r.status = tfsq_pkg::ST_CONTRA;
                     r.answer_kind = tfsq_pkg::AK_CONTRA;
                     r.match_count = (hits + opp > 255) ? 8'd255 : 8'(hits + opp);
                  end else if (hits > 1) begin
                     r.status = tfsq_pkg::ST_AMBIG;
                     r.answer_kind = tfsq_pkg::AK_AMBIG;
                     r.match_count = 8'(hits);
                  end else begin
                     r.status = tfsq_pkg::ST_OK;
                     r.answer_kind = tfsq_pkg::AK_DIRECT;
                     r.match_count = 8'd1;
                  end
               end
            end
         end
         tfsq_pkg::CMD_CLEAR: begin
            store_count = 0;
            store_contra = 0;
            r.status = tfsq_pkg::ST_OK;
         end
         default: r.status = tfsq_pkg::ST_BADARG;
      endcase
      r.stored_facts = 8'(store_count);
      r.contradiction_total = 16'(store_contra);
      return r;
   endfunction

   // Offer one word and hold it until taken
   task automatic send_word(tfsq_pkg::req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= q;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pending_answers.push_back(predict_answer(q));
      words_sent++;
   endtask

   function automatic tfsq_pkg::req_type make_word(tfsq_pkg::cmd_type c, int s, int p,
                                                   int o, bit n, bit sv = 0, bit pv = 0,
                                                   bit ov = 0);
      tfsq_pkg::req_type q;
      q.command = c;
      q.subject_value = 16'(s);
      q.predicate_value = 16'(p);
      q.object_value = 16'(o);
      q.negated = n;
      q.subject_is_variable = sv;
      q.predicate_is_variable = pv;
      q.object_is_variable = ov;
      return q;
   endfunction

   // Random word from a narrow value pool so that matches are common
   function automatic tfsq_pkg::req_type random_word();
      tfsq_pkg::req_type q;
      int                k;
      q.subject_value = 16'($urandom);
      q.predicate_value = 16'($urandom);
      q.object_value = 16'($urandom);
      q.subject_is_variable = 1'($urandom);
      q.predicate_is_variable = 1'($urandom);
      q.object_is_variable = 1'($urandom);
      q.negated = 1'($urandom);
      k = $urandom_range(99);
      if (k < 45) q.command = tfsq_pkg::CMD_ADD;
      else if (k < 92) q.command = tfsq_pkg::CMD_QUERY;
      else if (k < 96) q.command = tfsq_pkg::CMD_CLEAR;
      else q.command = tfsq_pkg::CMD_BAD;
      if ($urandom_range(9) < 8) begin
         q.subject_value = 16'($urandom_range(3));
         q.predicate_value = 16'($urandom_range(3));
         q.object_value = 16'($urandom_range(3));
         if ($urandom_range(19) == 0) q.object_value = 16'($urandom_range(15));
      end
      if (q.command == tfsq_pkg::CMD_QUERY && $urandom_range(9) < 3) begin
         q.subject_is_variable = 1'b0;
         q.predicate_is_variable = 1'b0;
         q.object_is_variable = 1'b0;
      end
      return q;
   endfunction

   // Stop offering and wait for every expected result
   task automatic wait_drained();
      req.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_word(make_word(tfsq_pkg::CMD_QUERY, 0, 0, 0, 0));
      send_word(make_word(tfsq_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
      send_word(make_word(tfsq_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
      send_word(make_word(tfsq_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1, 1, 1));
      send_word(make_word(tfsq_pkg::CMD_ADD, 1, 1, 2, 0));
      send_word(make_word(tfsq_pkg::CMD_ADD, 1, 2, 2, 0));
      send_word(make_word(tfsq_pkg::CMD_ADD, 1, 2, 2, 1));
      send_word(make_word(tfsq_pkg::CMD_QUERY, 0, 0, 0, 0, 1, 1, 1));
      send_word(make_word(tfsq_pkg::CMD_QUERY, 0, 0, 1, 0, 1, 1, 1));
      send_word(make_word(tfsq_pkg::CMD_QUERY, 7, 7, 2, 0, 1, 1, 0));
      send_word(make_word(tfsq_pkg::CMD_QUERY, 1, 2, 2, 0));
      send_word(make_word(tfsq_pkg::CMD_QUERY, 8, 2, 2, 0, 1, 0, 0));
      send_word(make_word(tfsq_pkg::CMD_QUERY, 1, 16'hFFFF, 2, 0, 0, 1, 0));
      send_word(make_word(tfsq_pkg::CMD_QUERY, 1, 1, 8, 1, 0, 0, 1));
      send_word(make_word(tfsq_pkg::CMD_BAD, 5, 5, 5, 1));
      send_word(make_word(tfsq_pkg::CMD_CLEAR, 0, 0, 0, 0));
      send_word(make_word(tfsq_pkg::CMD_QUERY, 0, 0, 0, 1, 1, 1, 1));
      wait_drained();
   endtask

   // Fill to the top, check full, then query the stored facts with two patterns
   task automatic test_full_store();
      for (int i = 0; i < tfsq_pkg::FACT_DEPTH + 2; i++)
         send_word(make_word(tfsq_pkg::CMD_ADD, 3, i % 40, 0, i >= 40));
      send_word(make_word(tfsq_pkg::CMD_QUERY, 3, 0, 0, 0, 0, 1, 0));
      send_word(make_word(tfsq_pkg::CMD_QUERY, 3, 5, 0, 1, 0, 0, 0));
      send_word(make_word(tfsq_pkg::CMD_CLEAR, 0, 0, 0, 0));
   endtask

   // Random mix, clearing now and then once the store is well filled
   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 3 && store_count > 40)
            send_word(make_word(tfsq_pkg::CMD_CLEAR, 0, 0, 0, 0));
         else send_word(random_word());
      end
   endtask

   // Receiver holds off while the sender keeps offering words
   task automatic test_back_pressure();
      hold_off_trigger++;
      test_random(10);
      wait_drained();
   endtask

   // Receiver: stall at random, with a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_seen != hold_off_trigger) begin
         hold_seen <= hold_off_trigger;
         hold_left <= HOLD_OFF_CYCLES;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each taken result with the oldest prediction
   always @(posedge clock) begin
      tfsq_pkg::rsp_type e, a;
      if (!reset && rsp.valid && rsp.ready) begin
         a = rsp.payload;
         if (pending_answers.size() == 0) begin
            $error("unexpected result word");
            fail_count++;
         end else begin
            e = pending_answers.pop_front();
            words_checked++;
            if (a.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, a.status); fail_count++; end
            if (a.answer_kind !== e.answer_kind) begin
               $error("answer_kind exp %0d got %0d", e.answer_kind, a.answer_kind);
               fail_count++; end
            if (a.found_subject !== e.found_subject) begin
               $error("found_subject exp %0h got %0h", e.found_subject, a.found_subject);
               fail_count++; end
            if (a.found_predicate !== e.found_predicate) begin
               $error("found_predicate exp %0h got %0h", e.found_predicate,
                      a.found_predicate); fail_count++; end
            if (a.found_object !== e.found_object) begin
               $error("found_object exp %0h got %0h", e.found_object, a.found_object);
               fail_count++; end
            if (a.found_negated !== e.found_negated) begin
               $error("found_negated exp %0d got %0d", e.found_negated, a.found_negated);
               fail_count++; end
            if (a.found_index !== e.found_index) begin
               $error("found_index exp %0d got %0d", e.found_index, a.found_index);
               fail_count++; end
            if (a.match_count !== e.match_count) begin
               $error("match_count exp %0d got %0d", e.match_count, a.match_count);
               fail_count++; end
            if (a.stored_facts !== e.stored_facts) begin
               $error("stored_facts exp %0d got %0d", e.stored_facts, a.stored_facts);
               fail_count++; end
            if (a.contradiction_total !== e.contradiction_total) begin
               $error("contradiction_total exp %0d got %0d", e.contradiction_total,
                      a.contradiction_total); fail_count++; end
         end
      end
   end

   // Watchdog: count cycles with no accepted word on either side
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      words_sent = 0;
      store_count = 0;
      store_contra = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_store();
      wait_drained();
      test_random(280);
      send_idle_pct = 46;
      test_random(280);
      send_idle_pct = 0;
      recv_stall_pct = 46;
      test_random(280);
      // Pause the sender until everything has come back
      wait_drained();
      send_idle_pct = 8;
      recv_stall_pct = 8;
      test_random(150);
      test_back_pressure();
      recv_stall_pct = 0;
      send_idle_pct = 0;
      test_full_store();

      wait_drained();
      repeat (tfsq_pkg::FACT_DEPTH + 10) @(posedge clock);
      $display("Ran %0d words (adds, queries, clears, bad commands), %0d results checked,",
               words_sent, words_checked);
      $display("with full store, variable binding and back-pressure phases.");
      if (fail_count == 0 && pending_answers.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
